@@ sv/unix_time_civil_converter_core_macros.svh @@
// ----------------------------------------------------------------------------
// UNIX time / civil date converter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef UNIX_TIME_CIVIL_CONVERTER_CORE_MACROS_SVH
`define UNIX_TIME_CIVIL_CONVERTER_CORE_MACROS_SVH

// Same-cycle implication.
`define UCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ucc_pkg.sv @@
// ----------------------------------------------------------------------------
// UNIX time / civil date converter package
// Pipeline depth, stage enable type, calendar constants and month table.
// ----------------------------------------------------------------------------
package ucc_pkg;

  localparam int NumStages = 9;

  typedef logic [NumStages-1:0] stage_vec_t;

  // Seconds to civil: bias so that the shifted seconds stay non-negative
  // (24856 days of 86400 seconds).
  localparam logic [32:0] SecBias      = 33'd2147558400;
  localparam logic [26:0] Recip675     = 27'd101806633;  // 2^36 / 675, rounded up
  localparam logic [19:0] DayShift     = 20'd694612;     // 719468 - 24856
  localparam logic [19:0] FourCycles   = 20'd584388;     // 4 * 146097
  localparam logic [19:0] FiveCycles   = 20'd730485;     // 5 * 146097
  localparam logic [19:0] CycleDays    = 20'd146097;
  localparam logic [13:0] Recip3600    = 14'd9321;       // 2^21 / 225, rounded up
  localparam logic [16:0] Recip1460    = 17'd91930;      // 2^25 / 365, rounded up
  localparam logic [18:0] Recip365     = 19'd367720;     // 2^27 / 365, rounded up
  localparam logic [10:0] Recip60      = 11'd1093;       // 2^14 / 15, rounded up
  localparam logic [11:0] Recip153     = 12'd3427;       // 2^19 / 153, rounded up

  // Civil to seconds.
  localparam logic [9:0]  Recip400     = 10'd656;        // 2^14 / 25, rounded up
  localparam logic signed [21:0] MarchShift = 22'sd719468;

  // Days from March 1 to the start of a March-based month.
  function automatic logic [8:0] month_start(input logic [3:0] mshift);
    logic [8:0] days;
    case (mshift)
      4'd0:    days = 9'd0;
      4'd1:    days = 9'd31;
      4'd2:    days = 9'd61;
      4'd3:    days = 9'd92;
      4'd4:    days = 9'd122;
      4'd5:    days = 9'd153;
      4'd6:    days = 9'd184;
      4'd7:    days = 9'd214;
      4'd8:    days = 9'd245;
      4'd9:    days = 9'd275;
      4'd10:   days = 9'd306;
      4'd11:   days = 9'd337;
      4'd12:   days = 9'd367;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

@@ sv/ucc_sec2civ.sv @@
// ----------------------------------------------------------------------------
// UNIX seconds to civil date pipeline
// Nine register stages; constant divisions are done by reciprocal multiply.
// ----------------------------------------------------------------------------
module ucc_sec2civ (
  input  logic               clk,
  input  ucc_pkg::stage_vec_t adv,
  input  logic               kind,
  input  logic signed [31:0] epoch_seconds,
  output logic [10:0]        year_out,
  output logic [3:0]         month_out,
  output logic [4:0]         day_out,
  output logic [4:0]         hour_out,
  output logic [5:0]         minute_out,
  output logic [5:0]         second_out
);
  import ucc_pkg::*;

  logic        k1, k2, k3, k4, k5, k6, k7, k8;
  logic [32:0] u1, u2;
  logic [16:0] q2;
  logic [16:0] rem3, rem4;
  logic [19:0] n3;
  logic [17:0] dc4, dc5, dc6;
  logic        hi4, hi5, hi6, hi7, hi8;
  logic [4:0]  hour4, hour5, hour6, hour7, hour8;
  logic [17:0] t5;
  logic [11:0] r3600_5, r3600_6;
  logic [8:0]  yc6, yc7, yc8;
  logic [5:0]  minute6, minute7, minute8;
  logic [8:0]  dy7, dy8;
  logic [5:0]  second7, second8;
  logic [3:0]  mp8;

  logic [52:0] q_prod;
  logic [25:0] r675_full;
  logic        n_hi;
  logic [19:0] dc_full;
  logic [26:0] hour_prod;
  logic [32:0] a_prod;
  logic [2:0]  cent_cnt;
  logic        last_day;
  logic [17:0] t_full;
  logic [16:0] r3600_full;
  logic [36:0] yc_prod;
  logic [20:0] min_prod;
  logic [1:0]  yc_cent;
  logic [17:0] yday;
  logic [17:0] dy_full;
  logic [11:0] sec_full;
  logic [10:0] mp_num;
  logic [22:0] mp_prod;
  logic [3:0]  mon;
  logic [8:0]  day_full;
  logic [10:0] year_full;

  always_comb begin
    q_prod     = 53'(u1[32:7]) * 53'(Recip675);
    r675_full  = u2[32:7] - 26'(26'(q2) * 26'd675);
    n_hi       = n3 >= FiveCycles;
    dc_full    = n3 - FourCycles - (n_hi ? CycleDays : 20'd0);
    hour_prod  = 27'(rem3[16:4]) * 27'(Recip3600);
    a_prod     = 33'(dc4[17:2]) * 33'(Recip1460);
    cent_cnt   = 3'(dc4 >= 18'd36524) + 3'(dc4 >= 18'd73048) +
                 3'(dc4 >= 18'd109572) + 3'(dc4 >= 18'd146096);
    last_day   = dc4 == 18'd146096;
    t_full     = dc4 - 18'(a_prod[31:25]) + 18'(cent_cnt) - 18'(last_day);
    r3600_full = rem4 - 17'(17'(hour4) * 17'd3600);
    yc_prod    = 37'(t5) * 37'(Recip365);
    min_prod   = 21'(r3600_5[11:2]) * 21'(Recip60);
    yc_cent    = 2'(yc6 >= 9'd100) + 2'(yc6 >= 9'd200) + 2'(yc6 >= 9'd300);
    yday       = 18'(18'(yc6) * 18'd365) + 18'(yc6[8:2]) - 18'(yc_cent);
    dy_full    = dc6 - yday;
    sec_full   = r3600_6 - 12'(12'(minute6) * 12'd60);
    mp_num     = 11'(11'(dy7) * 11'd5) + 11'd2;
    mp_prod    = 23'(mp_num) * 23'(Recip153);
    mon        = (mp8 < 4'd10) ? mp8 + 4'd3 : mp8 - 4'd9;
    day_full   = dy8 - month_start(mp8) + 9'd1;
    year_full  = 11'(yc8) + (hi8 ? 11'd2000 : 11'd1600) + 11'(mon <= 4'd2);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      k1 <= kind;
      u1 <= {epoch_seconds[31], epoch_seconds} + SecBias;
    end
    if (adv[1]) begin
      k2 <= k1;
      u2 <= u1;
      q2 <= q_prod[52:36];
    end
    if (adv[2]) begin
      k3   <= k2;
      rem3 <= {r675_full[9:0], u2[6:0]};
      n3   <= 20'(q2) + DayShift;
    end
    if (adv[3]) begin
      k4    <= k3;
      rem4  <= rem3;
      dc4   <= dc_full[17:0];
      hi4   <= n_hi;
      hour4 <= hour_prod[25:21];
    end
    if (adv[4]) begin
      k5      <= k4;
      hi5     <= hi4;
      dc5     <= dc4;
      t5      <= t_full;
      hour5   <= hour4;
      r3600_5 <= r3600_full[11:0];
    end
    if (adv[5]) begin
      k6      <= k5;
      hi6     <= hi5;
      dc6     <= dc5;
      yc6     <= yc_prod[35:27];
      hour6   <= hour5;
      r3600_6 <= r3600_5;
      minute6 <= min_prod[19:14];
    end
    if (adv[6]) begin
      k7      <= k6;
      hi7     <= hi6;
      yc7     <= yc6;
      dy7     <= dy_full[8:0];
      hour7   <= hour6;
      minute7 <= minute6;
      second7 <= sec_full[5:0];
    end
    if (adv[7]) begin
      k8      <= k7;
      hi8     <= hi7;
      yc8     <= yc7;
      dy8     <= dy7;
      mp8     <= mp_prod[22:19];
      hour8   <= hour7;
      minute8 <= minute7;
      second8 <= second7;
    end
    if (adv[8]) begin
      // zero the civil fields of a civil-to-seconds word
      if (!k8) begin
        year_out   <= year_full;
        month_out  <= mon;
        day_out    <= day_full[4:0];
        hour_out   <= hour8;
        minute_out <= minute8;
        second_out <= second8;
      end else begin
        year_out   <= '0;
        month_out  <= '0;
        day_out    <= '0;
        hour_out   <= '0;
        minute_out <= '0;
        second_out <= '0;
      end
    end
  end

endmodule

@@ sv/ucc_civ2sec.sv @@
// ----------------------------------------------------------------------------
// Civil date to UNIX seconds pipeline
// Day number from era and day of era, scaled to seconds, range checked.
// ----------------------------------------------------------------------------
module ucc_civ2sec (
  input  logic                clk,
  input  ucc_pkg::stage_vec_t adv,
  input  logic                kind,
  input  logic [11:0]         year_in,
  input  logic [3:0]          month_in,
  input  logic [4:0]          day_in,
  input  logic [4:0]          hour_in,
  input  logic [5:0]          minute_in,
  input  logic [5:0]          second_in,
  output logic signed [31:0]  seconds_out,
  output logic                overflow
);
  import ucc_pkg::*;

  logic        k1, k2, k3, k4, k5, k6, k7, k8;
  logic [11:0] y1;
  logic [3:0]  m1;
  logic [4:0]  d1, d2;
  logic [4:0]  h1;
  logic [5:0]  mi1, s1;
  logic [12:0] yp2, yp3;
  logic [3:0]  ms2;
  logic [16:0] tod2, tod3, tod4, tod5, tod6, tod7;
  logic [3:0]  cq3;
  logic signed [9:0]  dy3, dy4;
  logic [8:0]  yc4;
  logic signed [4:0]  cyc4;
  logic signed [18:0] dc5;
  logic signed [21:0] cycm5;
  logic signed [21:0] daynum6;
  logic signed [39:0] total7, total8;

  logic        early;
  logic [18:0] cq_prod;
  logic [12:0] yc_full;
  logic [1:0]  yc_cent;
  logic [17:0] yday;

  always_comb begin
    early   = m1 <= 4'd2;
    cq_prod = 19'(yp2[12:4]) * 19'(Recip400);
    yc_full = yp3 - 13'(13'(cq3) * 13'd400);
    yc_cent = 2'(yc4 >= 9'd100) + 2'(yc4 >= 9'd200) + 2'(yc4 >= 9'd300);
    yday    = 18'(18'(yc4) * 18'd365) + 18'(yc4[8:2]) - 18'(yc_cent);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      k1  <= kind;
      y1  <= year_in;
      m1  <= month_in;
      d1  <= day_in;
      h1  <= hour_in;
      mi1 <= minute_in;
      s1  <= second_in;
    end
    if (adv[1]) begin
      k2 <= k1;
      // offset by one era so the floor division stays non-negative
      yp2  <= 13'(y1) + 13'd400 - 13'(early);
      ms2  <= early ? m1 + 4'd9 : m1 - 4'd3;
      d2   <= d1;
      tod2 <= 17'(17'(h1) * 17'd3600) + 17'(17'(mi1) * 17'd60) + 17'(s1);
    end
    if (adv[2]) begin
      k3   <= k2;
      yp3  <= yp2;
      cq3  <= cq_prod[17:14];
      dy3  <= $signed({1'b0, month_start(ms2)}) + $signed({5'd0, d2}) - 10'sd1;
      tod3 <= tod2;
    end
    if (adv[3]) begin
      k4   <= k3;
      yc4  <= yc_full[8:0];
      cyc4 <= $signed({1'b0, cq3}) - 5'sd1;
      dy4  <= dy3;
      tod4 <= tod3;
    end
    if (adv[4]) begin
      k5    <= k4;
      dc5   <= $signed({1'b0, yday}) + dy4;
      cycm5 <= cyc4 * 22'sd146097;
      tod5  <= tod4;
    end
    if (adv[5]) begin
      k6      <= k5;
      daynum6 <= cycm5 + dc5 - MarchShift;
      tod6    <= tod5;
    end
    if (adv[6]) begin
      k7     <= k6;
      total7 <= daynum6 * 40'sd86400;
      tod7   <= tod6;
    end
    if (adv[7]) begin
      k8     <= k7;
      total8 <= total7 + $signed({23'd0, tod7});
    end
    if (adv[8]) begin
      // zero the seconds fields of a seconds-to-civil word
      if (k8) begin
        seconds_out <= total8[31:0];
        overflow    <= (total8[39:31] != '0) && (total8[39:31] != '1);
      end else begin
        seconds_out <= '0;
        overflow    <= 1'b0;
      end
    end
  end

endmodule

@@ sv/unix_time_civil_converter_core.sv @@
// ----------------------------------------------------------------------------
// UNIX time / civil date converter core
// Converts signed 32-bit UNIX seconds to a civil date and time, or back.
// ----------------------------------------------------------------------------
//  port group   direction  handshake            word
//  input        in         in_valid / in_stall  kind, epoch_seconds, *_in
//  result       out        out_valid/out_stall  seconds_out, overflow, *_out
//
//  Nine register stages: a word enters stage 0 on the accepting edge and
//  out_valid is the valid bit of the last stage; while out_stall is low, one
//  word per cycle enters and leaves the pipeline of constant multiplies.
//  Reset clears the stage valid bits only; data registers are not reset.
//  A stall on the result side backs up stage by stage; empty stages still
//  fill, so in_stall rises only once every stage holds a word.
// ----------------------------------------------------------------------------
module unix_time_civil_converter_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic signed [31:0] epoch_seconds,
  input  logic [11:0]        year_in,
  input  logic [3:0]         month_in,
  input  logic [4:0]         day_in,
  input  logic [4:0]         hour_in,
  input  logic [5:0]         minute_in,
  input  logic [5:0]         second_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] seconds_out,
  output logic               overflow,
  output logic [10:0]        year_out,
  output logic [3:0]         month_out,
  output logic [4:0]         day_out,
  output logic [4:0]         hour_out,
  output logic [5:0]         minute_out,
  output logic [5:0]         second_out
);
  import ucc_pkg::*;

  stage_vec_t vld;
  stage_vec_t adv;

  // a stage loads when it is empty or its word moves on
  always_comb begin
    adv[NumStages-1] = !vld[NumStages-1] || !out_stall;
    for (int i = NumStages - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld[NumStages-1];

  ucc_sec2civ u_sec2civ (
    .clk           (clk),
    .adv           (adv),
    .kind          (kind),
    .epoch_seconds (epoch_seconds),
    .year_out      (year_out),
    .month_out     (month_out),
    .day_out       (day_out),
    .hour_out      (hour_out),
    .minute_out    (minute_out),
    .second_out    (second_out)
  );

  ucc_civ2sec u_civ2sec (
    .clk         (clk),
    .adv         (adv),
    .kind        (kind),
    .year_in     (year_in),
    .month_in    (month_in),
    .day_in      (day_in),
    .hour_in     (hour_in),
    .minute_in   (minute_in),
    .second_in   (second_in),
    .seconds_out (seconds_out),
    .overflow    (overflow)
  );

endmodule

@@ sv/ucc_checker.sv @@
// ----------------------------------------------------------------------------
// UNIX time / civil date converter port checker
// Watches the core's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "unix_time_civil_converter_core_macros.svh"

module ucc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] seconds_out,
  input logic               overflow,
  input logic [10:0]        year_out,
  input logic [3:0]         month_out,
  input logic [4:0]         day_out,
  input logic [4:0]         hour_out,
  input logic [5:0]         minute_out,
  input logic [5:0]         second_out
);

  logic in_seen;
  assign in_seen = in_valid;

  `UCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result word dropped")
  `UCC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(seconds_out) && $stable(overflow) && $stable(year_out) && $stable(day_out) && $stable(second_out), "stalled result word changed")
  `UCC_ASSERT_NOW(a_kind_excl, out_valid, year_out == 11'd0 || (seconds_out == 32'sd0 && !overflow), "result carries both kinds")
  `UCC_ASSERT_NOW(a_civil_range, out_valid && year_out != 11'd0, month_out >= 4'd1 && month_out <= 4'd12 && day_out != 5'd0 && hour_out <= 5'd23 && minute_out <= 6'd59 && second_out <= 6'd59, "civil field out of range")
  `UCC_ASSERT_NOW(a_empty_ready, !out_valid && (in_seen || !in_seen), !in_stall, "input stalled with empty output")

endmodule

bind unix_time_civil_converter_core ucc_checker u_ucc_checker (.*);
